/* hdl/blpht_pkg.sv */
// ----------------------------------------------------------------------------
// blpht_pkg
// Shared types and constants of the bucketed linear probe hash table unit.
// ----------------------------------------------------------------------------
package blpht_pkg;

    localparam int SLOTS_PER_BUCKET = 5;
    localparam int MAX_BUCKETS      = 256;
    localparam int MAX_LOG2         = $clog2(MAX_BUCKETS);
    localparam int TOTAL_SLOTS      = MAX_BUCKETS * SLOTS_PER_BUCKET;
    localparam int KEY_BITS         = 64;
    localparam int VALUE_BITS       = 32;
    localparam int HASH_W           = 11;
    localparam int LOG2_W           = 4;
    localparam int BKT_W            = MAX_LOG2;
    localparam int IDX_W            = $clog2(TOTAL_SLOTS);
    localparam int SEL_W            = $clog2(SLOTS_PER_BUCKET);
    localparam int CNT_W            = $clog2(TOTAL_SLOTS + 1);
    localparam int QUO_W            = HASH_W - SEL_W + 1;

    // hash / SLOTS_PER_BUCKET as a multiply by a scaled reciprocal
    localparam int RECIP_SHIFT      = 16;
    localparam int DIV_RECIP        = (1 << RECIP_SHIFT) / SLOTS_PER_BUCKET + 1;
    localparam int RECIP_W          = $clog2(DIV_RECIP + 1);
    localparam int PROD_W           = HASH_W + RECIP_W;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_LOOKUP = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_UNUSED = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_FOUND     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FULL      = 3'd4,
        ST_CLEARED   = 3'd5
    } t_status;

endpackage

/* hdl/bucketed_linear_probe_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// bucketed_linear_probe_hash_table_unit
// Open addressing hash table of five-slot buckets with linear probing.
// ----------------------------------------------------------------------------
// One item is taken at a time. Insert and lookup pass through the setup
// states S_DIV and S_ADDR, then S_READ and S_CHECK for every slot probed,
// then S_DONE; the pace is set by the registered read ports of the key and
// value memories, which are read once per probed slot. Clear and the unused
// command go straight to S_DONE. Clear takes effect at once
// through one valid bit per bucket, so there is no clearing pass after
// reset or clear. A new item is accepted while the previous result still
// waits in the output register.
module bucketed_linear_probe_hash_table_unit
    import blpht_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,       // bucket_count_log2
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [111:0]  i_s_axis_tdata,    // key[63:0], store_value[95:64],
                                             // slot_hash[106:96], zero pad
    input  logic [1:0]    i_s_axis_tuser,    // command[1:0]
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [31:0]   o_m_axis_tdata,    // found_value[31:0]
    output logic [2:0]    o_m_axis_tuser     // status[2:0]
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_DIV   = 6'b000010,
        S_ADDR  = 6'b000100,
        S_READ  = 6'b001000,
        S_CHECK = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                     r_state, n_state;
    logic [LOG2_W-1:0]          r_log2;
    logic [MAX_BUCKETS-1:0]     r_row_valid, n_row_valid;
    t_cmd                       r_cmd, n_cmd;
    logic [KEY_BITS-1:0]        r_key, n_key;
    logic [VALUE_BITS-1:0]      r_val, n_val;
    logic [HASH_W-1:0]          r_hash, n_hash;
    logic [BKT_W-1:0]           r_bucket, n_bucket;
    logic [SEL_W-1:0]           r_slot, n_slot;
    logic [IDX_W-1:0]           r_idx, n_idx;
    logic [CNT_W-1:0]           r_left, n_left;
    t_status                    r_res_status, n_res_status;
    logic [VALUE_BITS-1:0]      r_res_value, n_res_value;
    logic                       r_out_valid, n_out_valid;
    t_status                    r_out_status, n_out_status;
    logic [VALUE_BITS-1:0]      r_out_value, n_out_value;

    // table storage
    logic [KEY_BITS-1:0]          r_key_mem [TOTAL_SLOTS];
    logic [VALUE_BITS-1:0]        r_val_mem [TOTAL_SLOTS];
    logic [SLOTS_PER_BUCKET-1:0]  r_occ_mem [MAX_BUCKETS];
    logic [KEY_BITS-1:0]          r_key_rd;
    logic [VALUE_BITS-1:0]        r_val_rd;
    logic [SLOTS_PER_BUCKET-1:0]  r_occ_rd;

    logic                         w_in_xfer;
    logic                         w_out_xfer;
    logic [LOG2_W-1:0]            w_eff_log2;
    logic [BKT_W-1:0]             w_bkt_mask;
    logic [CNT_W-1:0]             w_limit;
    logic [PROD_W-1:0]            w_prod;
    logic [QUO_W-1:0]             w_quo;
    logic [HASH_W-1:0]            w_quo5;
    logic [SLOTS_PER_BUCKET-1:0]  w_occ_row;
    logic                         w_occupied;
    logic                         w_wr_en;
    logic [SLOTS_PER_BUCKET-1:0]  w_occ_new;

    assign w_in_xfer  = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_xfer = r_out_valid && i_m_axis_tready;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_value;
    assign o_m_axis_tuser  = r_out_status;

    // buckets in use saturate at the table size
    assign w_eff_log2 = (r_log2 >= LOG2_W'(MAX_LOG2)) ? LOG2_W'(MAX_LOG2) : r_log2;
    assign w_bkt_mask = BKT_W'((32'd1 << w_eff_log2) - 32'd1);
    assign w_limit    = CNT_W'(SLOTS_PER_BUCKET << w_eff_log2);

    assign w_prod = PROD_W'(r_hash) * PROD_W'(DIV_RECIP);
    assign w_quo  = w_prod[PROD_W-1 -: QUO_W];
    assign w_quo5 = HASH_W'(w_quo) * HASH_W'(SLOTS_PER_BUCKET);

    // a bucket row that is not valid reads as empty
    assign w_occ_row  = r_row_valid[r_bucket] ? r_occ_rd : '0;
    assign w_occupied = w_occ_row[r_slot];
    assign w_wr_en    = (r_state == S_CHECK) && !w_occupied && (r_cmd == CMD_INSERT);
    assign w_occ_new  = w_occ_row | SLOTS_PER_BUCKET'(1 << r_slot);

    always_comb begin
        n_state      = r_state;
        n_row_valid  = r_row_valid;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_val        = r_val;
        n_hash       = r_hash;
        n_bucket     = r_bucket;
        n_slot       = r_slot;
        n_idx        = r_idx;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_value  = r_res_value;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_value  = r_out_value;

        if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_cmd        = t_cmd'(i_s_axis_tuser);
                    n_key        = i_s_axis_tdata[63:0];
                    n_val        = i_s_axis_tdata[95:64];
                    n_hash       = i_s_axis_tdata[106:96];
                    n_res_value  = '0;
                    n_res_status = ST_NOT_FOUND;
                    unique case (t_cmd'(i_s_axis_tuser))
                        CMD_CLEAR: begin
                            n_row_valid  = '0;
                            n_res_status = ST_CLEARED;
                            n_state      = S_DONE;
                        end
                        CMD_UNUSED: begin
                            n_state = S_DONE;
                        end
                        CMD_INSERT: begin
                            n_res_status = ST_FULL;
                            n_state      = S_DIV;
                        end
                        CMD_LOOKUP: begin
                            n_state = S_DIV;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_DIV: begin
                n_bucket = w_quo[BKT_W-1:0] & w_bkt_mask;
                n_slot   = SEL_W'(r_hash - w_quo5);
                n_left   = w_limit;
                n_state  = S_ADDR;
            end
            S_ADDR: begin
                n_idx   = IDX_W'(r_bucket) * IDX_W'(SLOTS_PER_BUCKET) + IDX_W'(r_slot);
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                priority if (!w_occupied) begin
                    if (r_cmd == CMD_INSERT) begin
                        n_row_valid[r_bucket] = 1'b1;
                        n_res_status = ST_INSERTED;
                    end else begin
                        n_res_status = ST_NOT_FOUND;
                    end
                    n_state = S_DONE;
                end else if (r_key_rd == r_key) begin
                    if (r_cmd == CMD_INSERT) begin
                        n_res_status = ST_DUPLICATE;
                    end else begin
                        n_res_status = ST_FOUND;
                        n_res_value  = r_val_rd;
                    end
                    n_state = S_DONE;
                end else if (r_left == CNT_W'(1)) begin
                    // every slot of the buckets in use visited
                    n_state = S_DONE;
                end else begin
                    n_left = r_left - CNT_W'(1);
                    if (r_slot == SEL_W'(SLOTS_PER_BUCKET - 1)) begin
                        n_slot = '0;
                        if (r_bucket == w_bkt_mask) begin
                            n_bucket = '0;
                            n_idx    = '0;
                        end else begin
                            n_bucket = r_bucket + BKT_W'(1);
                            n_idx    = r_idx + IDX_W'(1);
                        end
                    end else begin
                        n_slot = r_slot + SEL_W'(1);
                        n_idx  = r_idx + IDX_W'(1);
                    end
                    n_state = S_READ;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_value  = r_res_value;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_log2      <= LOG2_W'(MAX_LOG2);
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_row_valid <= n_row_valid;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_log2 <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_val        <= n_val;
        r_hash       <= n_hash;
        r_bucket     <= n_bucket;
        r_slot       <= n_slot;
        r_idx        <= n_idx;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_value  <= n_res_value;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
    end

    // slot memories, one registered read port each
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_key_mem[r_idx]    <= r_key;
            r_val_mem[r_idx]    <= r_val;
            r_occ_mem[r_bucket] <= w_occ_new;
        end
        r_key_rd <= r_key_mem[r_idx];
        r_val_rd <= r_val_mem[r_idx];
        r_occ_rd <= r_occ_mem[r_bucket];
    end

`ifndef ASSERT_OFF
    a_idx_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ || r_state == S_CHECK) |->
        (r_idx == IDX_W'(r_bucket) * IDX_W'(SLOTS_PER_BUCKET) + IDX_W'(r_slot)))
        else $error("probe index out of step with bucket and slot");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_slot < SEL_W'(SLOTS_PER_BUCKET) && r_left != '0))
        else $error("probe slot or remaining count out of range");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_s_axis_tuser == CMD_CLEAR) |=> (r_row_valid == '0))
        else $error("clear left a bucket marked valid");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && r_out_valid && !i_m_axis_tready) |=>
        (r_state == S_DONE && $stable(r_out_status)))
        else $error("result overwrote a pending output transfer");
`endif

endmodule

/* dv/hash_table_checker.sv */
// ----------------------------------------------------------------------------
// hash_table_checker
// Watches the configuration port and both stream channels of the bucketed
// linear probe hash table unit. Keeps its own copy of the table, predicts
// the status and value of every accepted command and compares each result
// transfer in order with the oldest prediction.
// ----------------------------------------------------------------------------
module hash_table_checker
    import blpht_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [3:0]    i_cfg_wdata,
    input  logic          i_s_axis_tvalid,
    input  logic          i_s_axis_tready,
    input  logic [111:0]  i_s_axis_tdata,    // key[63:0], store_value[95:64],
                                             // slot_hash[106:96], zero pad
    input  logic [1:0]    i_s_axis_tuser,    // command[1:0]
    input  logic          i_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    input  logic [31:0]   i_m_axis_tdata,    // found_value[31:0]
    input  logic [2:0]    i_m_axis_tuser,    // status[2:0]
    output int            o_fail_count,
    output int            o_pending
);

    typedef struct {
        t_status      status;
        logic [31:0]  value;
    } t_lookup_result;

    logic [LOG2_W-1:0]      count_log2;
    logic                   slot_used [TOTAL_SLOTS];
    logic [KEY_BITS-1:0]    slot_key  [TOTAL_SLOTS];
    logic [VALUE_BITS-1:0]  slot_val  [TOTAL_SLOTS];
    t_lookup_result         expected_results [$];

    initial o_fail_count = 0;

    task automatic report(input string what, input logic [63:0] want,
                          input logic [63:0] got);
        $display("[%0t] mismatch: %s expected %0h got %0h", $time, what, want, got);
        o_fail_count++;
    endtask

    // walks the probe chain exactly as the table does and updates the copy
    function automatic t_lookup_result probe_table(input t_cmd cmd,
                                                   input logic [63:0] key,
                                                   input logic [31:0] val,
                                                   input logic [10:0] hash);
        t_lookup_result res;
        int buckets;
        int bucket;
        int slot;
        int idx;
        buckets = (count_log2 >= MAX_LOG2) ? MAX_BUCKETS : (1 << count_log2);
        res.value = '0;
        if (cmd == CMD_CLEAR) begin
            slot_used = '{default: 1'b0};
            res.status = ST_CLEARED;
            return res;
        end
        if (cmd == CMD_UNUSED) begin
            res.status = ST_NOT_FOUND;
            return res;
        end
        res.status = (cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
        bucket = (int'(hash) / SLOTS_PER_BUCKET) % buckets;
        slot = int'(hash) % SLOTS_PER_BUCKET;
        for (int n = 0; n < buckets * SLOTS_PER_BUCKET; n++) begin
            idx = bucket * SLOTS_PER_BUCKET + slot;
            if (!slot_used[idx]) begin
                if (cmd == CMD_INSERT) begin
                    slot_used[idx] = 1'b1;
                    slot_key[idx] = key;
                    slot_val[idx] = val;
                    res.status = ST_INSERTED;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
                break;
            end
            if (slot_key[idx] == key) begin
                if (cmd == CMD_INSERT) begin
                    res.status = ST_DUPLICATE;
                end else begin
                    res.status = ST_FOUND;
                    res.value = slot_val[idx];
                end
                break;
            end
            slot++;
            if (slot == SLOTS_PER_BUCKET) begin
                slot = 0;
                bucket = (bucket + 1) % buckets;
            end
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            count_log2 = LOG2_W'(MAX_LOG2);
            slot_used = '{default: 1'b0};
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                count_log2 = i_cfg_wdata;
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expected_results.push_back(probe_table(t_cmd'(i_s_axis_tuser),
                                                       i_s_axis_tdata[63:0],
                                                       i_s_axis_tdata[95:64],
                                                       i_s_axis_tdata[106:96]));
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_results.size() == 0) begin
                    report("result transfer with nothing outstanding", 0,
                           {29'd0, i_m_axis_tuser, i_m_axis_tdata});
                end else begin
                    want = expected_results.pop_front();
                    if (i_m_axis_tuser != want.status) begin
                        report("status", want.status, i_m_axis_tuser);
                    end
                    if (i_m_axis_tdata != want.value) begin
                        report("found_value", want.value, i_m_axis_tdata);
                    end
                end
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the bucketed linear probe hash table unit. A short
// directed sequence covers field extremes, every command, duplicates, table
// full and wrap-around; then random phases at several bucket counts reuse a
// small pool of keys so that chains grow, tables fill and lookups hit. Both
// stream sides idle at random; the receiver holds off once for a long time.
// ----------------------------------------------------------------------------
module testbench;
    import blpht_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int PHASE_ITEMS = 100;
    localparam int POOL_MAX    = 64;

    logic          clk = 1'b0;
    logic          rst_n;
    logic          cfg_we;
    logic [3:0]    cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [111:0]  s_tdata;
    logic [1:0]    s_tuser;
    logic          m_tvalid;
    logic          m_tready;
    logic [31:0]   m_tdata;
    logic [2:0]    m_tuser;

    int            fail_count;
    int            pending;
    int            n_sent = 0;
    int            n_results = 0;
    int            idle_cycles = 0;
    int            no_gap_left = 0;

    logic [63:0]   pool_key  [POOL_MAX];
    logic [10:0]   pool_hash [POOL_MAX];

    always #6 clk = ~clk;

    bucketed_linear_probe_hash_table_unit uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    hash_table_checker u_checker (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_cfg_we        (cfg_we),
        .i_cfg_wdata     (cfg_wdata),
        .i_s_axis_tvalid (s_tvalid),
        .i_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .i_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .i_m_axis_tdata  (m_tdata),
        .i_m_axis_tuser  (m_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // transfer counters and watchdog on cycles without any transfer
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (s_tvalid && s_tready) begin
            n_sent <= n_sent + 1;
        end
        if (m_tvalid && m_tready) begin
            n_results <= n_results + 1;
        end
    end

    // result side: short random stalls, ready streaks, one long hold-off
    initial begin
        int r;
        int hold_left;
        int ready_left;
        bit pressure_done;
        hold_left = 0;
        ready_left = 0;
        pressure_done = 0;
        m_tready <= 1'b0;
        forever begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!pressure_done && n_results >= 300) begin
                pressure_done = 1;
                hold_left = 400;
                m_tready <= 1'b0;
            end else if (ready_left > 0) begin
                ready_left--;
                m_tready <= 1'b1;
            end else if (r < 3) begin
                ready_left = $urandom_range(20, 80);
                m_tready <= 1'b1;
            end else if (r < 60) begin
                m_tready <= 1'b1;
            end else if (r < 95) begin
                hold_left = $urandom_range(0, 3);
                m_tready <= 1'b0;
            end else begin
                hold_left = $urandom_range(8, 40);
                m_tready <= 1'b0;
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gap_left > 0) begin
            no_gap_left--;
            return 0;
        end
        if (r < 3) begin
            no_gap_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // called at a clock edge; returns at the edge where the command transfers
    task automatic send_command(input t_cmd cmd, input logic [63:0] key,
                                input logic [31:0] val, input logic [10:0] hash);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, hash, val, key};
        s_tuser <= cmd;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (n_results != n_sent) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic set_bucket_log2(input logic [3:0] lg);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= lg;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        logic [3:0] phase_log2 [13];
        int buckets;
        int pool_n;
        int r;
        int k;
        t_cmd cmd;
        logic [63:0] key;
        logic [10:0] hash;

        phase_log2 = '{4'd0, 4'd1, 4'd2, 4'd3, 4'd15, 4'd4, 4'd0, 4'd2, 4'd8,
                       4'd1, 4'd3, 4'd9, 4'd0};
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= CMD_INSERT;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full table size after reset
        send_command(CMD_LOOKUP, 64'd0, 32'd0, 11'd0);
        send_command(CMD_INSERT, 64'd0, 32'd0, 11'd0);
        send_command(CMD_INSERT, '1, '1, 11'd1279);
        send_command(CMD_INSERT, 64'd0, 32'h1234_5678, 11'd0);
        send_command(CMD_LOOKUP, 64'd0, '1, 11'd0);
        send_command(CMD_LOOKUP, '1, 32'd0, 11'd1279);
        // start bucket beyond the buckets in use
        send_command(CMD_INSERT, 64'hA5A5_5A5A_C3C3_3C3C, 32'h5A5A_A5A5, 11'd2047);
        send_command(CMD_LOOKUP, 64'hA5A5_5A5A_C3C3_3C3C, 32'd0, 11'd2047);
        send_command(CMD_LOOKUP, 64'd5, 32'd0, 11'd0);
        send_command(CMD_UNUSED, '1, '1, 11'd2047);
        send_command(CMD_CLEAR, 64'd0, 32'd0, 11'd0);
        send_command(CMD_LOOKUP, 64'd0, 32'd0, 11'd0);

        // single bucket: wrap inside it, fill it, then scan it whole
        set_bucket_log2(4'd0);
        for (int i = 0; i < 6; i++) begin
            send_command(CMD_INSERT, 64'd100 + i, 32'hF000_0000 + i, 11'd4);
        end
        send_command(CMD_LOOKUP, 64'd999, 32'd0, 11'd2);
        send_command(CMD_LOOKUP, 64'd104, 32'd0, 11'd0);
        send_command(CMD_INSERT, 64'd100, 32'd7, 11'd3);

        foreach (phase_log2[p]) begin
            set_bucket_log2(phase_log2[p]);
            buckets = (phase_log2[p] >= MAX_LOG2) ? MAX_BUCKETS : (1 << phase_log2[p]);
            pool_n = (8 * buckets + 4 > POOL_MAX) ? POOL_MAX : 8 * buckets + 4;
            for (int i = 0; i < pool_n; i++) begin
                pool_key[i] = {$urandom, $urandom};
                if ($urandom_range(0, 3) != 0) begin
                    pool_hash[i] = 11'($urandom_range(0, buckets * SLOTS_PER_BUCKET - 1));
                end else begin
                    pool_hash[i] = 11'($urandom_range(0, 2047));
                end
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                r = $urandom_range(0, 99);
                if (r < 50) cmd = CMD_INSERT;
                else if (r < 94) cmd = CMD_LOOKUP;
                else if (r < 97) cmd = CMD_CLEAR;
                else cmd = CMD_UNUSED;
                k = $urandom_range(0, pool_n - 1);
                r = $urandom_range(0, 99);
                key = (r < 88) ? pool_key[k] : {$urandom, $urandom};
                hash = (r < 80) ? pool_hash[k] : 11'($urandom_range(0, 2047));
                send_command(cmd, key, $urandom, hash);
            end
        end

        wait_drained();
        repeat (16) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
